// File: hdl/hst_pkg.sv
// hst_pkg: shared types and codes for the handle slot table.
// No dependencies; used by hst_ctrl, hst_dp and handle_slot_table.
package hst_pkg;

	localparam logic [1:0] CMD_CLEAR   = 2'd0;
	localparam logic [1:0] CMD_INSERT  = 2'd1;
	localparam logic [1:0] CMD_RELEASE = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_UNKNOWN = 2'd2;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] block_address;
		logic [31:0] block_size;
		logic [31:0] handle_in;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] handle_out;
		logic [31:0] address_out;
		logic [31:0] size_out;
	} rsp_t;

	typedef enum logic [2:0] {
		FSM_INIT,
		FSM_IDLE,
		FSM_CLEAR,
		FSM_SCAN,
		FSM_DATA,
		FSM_DONE
	} fsm_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic clr_step;
		logic hnd_reset;
		logic scan_run;
		logic data_load;
		logic out_load;
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] req_cmd;
		logic       req_h_zero;
		logic       cnt_last;
		logic       hit;
		logic       miss;
		logic       is_insert;
		logic       out_free;
	} stat_t;

endpackage

// File: hdl/handle_slot_table.sv
// handle_slot_table: top level, table of SLOTS handle/address/size slots.
// Depends on hst_pkg, hst_ctrl and hst_dp.
//
//   channel | signals                   | payload        | moves on
//   --------+---------------------------+----------------+----------------------
//   request | req_valid, req_ready, req | hst_pkg::req_t | req_valid & req_ready
//   result  | rsp_valid, rsp_ready, rsp | hst_pkg::rsp_t | rsp_valid & rsp_ready
//
// Sequencing: one request at a time. Insert and release walk the handle memory
// one slot per cycle through a one-stage read pipeline; a release that hits
// adds a read of the address/size memories. Clear sweeps the handle memory.
// Unused code 3 and release of handle 0 go straight to the result load.
// Reset: a sweep zeroes the handle memory; req_ready stays low.
// Stalls: the result sits in an output register; a new request is taken while
// it waits, and only the final load of the next result waits on rsp_ready.
module handle_slot_table #(
	parameter int SLOTS = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  hst_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output hst_pkg::rsp_t rsp
);

	// command and status between controller and datapath
	hst_pkg::ctl_t  ctl;
	hst_pkg::stat_t stat;

	// controller: sequences clear sweep, slot scan, data fetch and result load
	hst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	// datapath: slot memories, scan pipeline, handle counter, result registers
	hst_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.ctl       (ctl),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

// File: hdl/hst_ctrl.sv
// hst_ctrl: sequencing state machine of the handle slot table.
// Depends on hst_pkg; drives hst_dp through ctl_t, reads stat_t.
module hst_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  hst_pkg::stat_t stat,
	output hst_pkg::ctl_t  ctl
);

	hst_pkg::fsm_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hst_pkg::FSM_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hst_pkg::FSM_INIT: begin
				if (stat.cnt_last) state_d = hst_pkg::FSM_IDLE;
			end
			hst_pkg::FSM_IDLE: begin
				if (req_valid) begin
					if (stat.req_cmd == hst_pkg::CMD_CLEAR) begin
						state_d = hst_pkg::FSM_CLEAR;
					end else if (stat.req_cmd == hst_pkg::CMD_INSERT) begin
						state_d = hst_pkg::FSM_SCAN;
					end else if (stat.req_cmd == hst_pkg::CMD_RELEASE && !stat.req_h_zero) begin
						state_d = hst_pkg::FSM_SCAN;
					end else begin
						state_d = hst_pkg::FSM_DONE;
					end
				end
			end
			hst_pkg::FSM_CLEAR: begin
				if (stat.cnt_last) state_d = hst_pkg::FSM_DONE;
			end
			hst_pkg::FSM_SCAN: begin
				if (stat.hit) begin
					state_d = stat.is_insert ? hst_pkg::FSM_DONE : hst_pkg::FSM_DATA;
				end else if (stat.miss) begin
					state_d = hst_pkg::FSM_DONE;
				end
			end
			hst_pkg::FSM_DATA: begin
				state_d = hst_pkg::FSM_DONE;
			end
			hst_pkg::FSM_DONE: begin
				if (stat.out_free) state_d = hst_pkg::FSM_IDLE;
			end
			default: begin
				state_d = hst_pkg::FSM_INIT;
			end
		endcase
	end

	always_comb begin
		ctl       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			hst_pkg::FSM_INIT: begin
				ctl.clr_step  = 1'b1;
				ctl.hnd_reset = stat.cnt_last;
			end
			hst_pkg::FSM_IDLE: begin
				req_ready   = 1'b1;
				ctl.capture = req_valid;
			end
			hst_pkg::FSM_CLEAR: begin
				ctl.clr_step  = 1'b1;
				ctl.hnd_reset = stat.cnt_last;
			end
			hst_pkg::FSM_SCAN: begin
				ctl.scan_run = 1'b1;
			end
			hst_pkg::FSM_DATA: begin
				ctl.data_load = 1'b1;
			end
			hst_pkg::FSM_DONE: begin
				ctl.out_load = stat.out_free;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

endmodule

// File: hdl/hst_dp.sv
// hst_dp: slot memories, scan pipeline, handle counter and result registers.
// Depends on hst_pkg; commanded by hst_ctrl.
module hst_dp #(
	parameter int SLOTS = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  hst_pkg::req_t  req,
	input  hst_pkg::ctl_t  ctl,
	output hst_pkg::stat_t stat,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output hst_pkg::rsp_t  rsp
);

	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

	logic [31:0] hmem [0:SLOTS-1];
	logic [31:0] amem [0:SLOTS-1];
	logic [31:0] smem [0:SLOTS-1];

	logic [1:0]    cmd_q;
	logic [31:0]   addr_q, size_q, h_q;
	logic [31:0]   nh_q;
	logic [AW-1:0] cnt_q;
	logic          iss_q;
	logic          vld_s1;
	logic [AW-1:0] idx_s1;
	logic [31:0]   hd_s1;
	logic [31:0]   a_rd_q, s_rd_q;
	hst_pkg::rsp_t res_q, out_q;
	hst_pkg::rsp_t res_init;
	logic          out_valid_q;

	logic cnt_last, rd_en, is_insert, match, hit, miss, rel_hit, out_free;

	assign cnt_last  = (cnt_q == LAST);
	assign rd_en     = ctl.scan_run && iss_q;
	assign is_insert = (cmd_q == hst_pkg::CMD_INSERT);
	assign match     = is_insert ? (hd_s1 == 32'd0) : (hd_s1 == h_q);
	assign hit       = ctl.scan_run && vld_s1 && match;
	assign miss      = ctl.scan_run && vld_s1 && !match && (idx_s1 == LAST);
	assign rel_hit   = hit && !is_insert;
	assign out_free  = !out_valid_q || rsp_ready;

	always_comb begin
		stat.req_cmd    = req.cmd;
		stat.req_h_zero = (req.handle_in == 32'd0);
		stat.cnt_last   = cnt_last;
		stat.hit        = hit;
		stat.miss       = miss;
		stat.is_insert  = is_insert;
		stat.out_free   = out_free;
	end

	// result seed at capture: release of handle 0 is unknown up front
	always_comb begin
		res_init        = '0;
		res_init.status = (req.cmd == hst_pkg::CMD_RELEASE && req.handle_in == 32'd0)
			? hst_pkg::ST_UNKNOWN : hst_pkg::ST_OK;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			iss_q       <= 1'b0;
			vld_s1      <= 1'b0;
			nh_q        <= 32'd1;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.capture) begin
				cnt_q  <= '0;
				iss_q  <= 1'b1;
				vld_s1 <= 1'b0;
			end else if (ctl.clr_step) begin
				cnt_q <= cnt_last ? '0 : cnt_q + AW'(1);
			end else if (ctl.scan_run) begin
				vld_s1 <= rd_en;
				if (rd_en) begin
					cnt_q <= cnt_last ? '0 : cnt_q + AW'(1);
					if (cnt_last) iss_q <= 1'b0;
				end
			end
			if (ctl.hnd_reset) begin
				nh_q <= 32'd1;
			end else if (hit && is_insert) begin
				nh_q <= (nh_q == 32'hFFFF_FFFF) ? 32'd1 : nh_q + 32'd1;
			end
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// handle memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (ctl.clr_step) begin
			hmem[cnt_q] <= 32'd0;
		end else if (hit) begin
			hmem[idx_s1] <= is_insert ? nh_q : 32'd0;
		end
		if (rd_en) begin
			hd_s1  <= hmem[cnt_q];
			idx_s1 <= cnt_q;
		end
	end

	always_ff @(posedge clk) begin
		if (hit && is_insert) begin
			amem[idx_s1] <= addr_q;
			smem[idx_s1] <= size_q;
		end
		if (rel_hit) begin
			a_rd_q <= amem[idx_s1];
			s_rd_q <= smem[idx_s1];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q  <= req.cmd;
			addr_q <= req.block_address;
			size_q <= req.block_size;
			h_q    <= req.handle_in;
			res_q  <= res_init;
		end else if (hit && is_insert) begin
			res_q.handle_out <= nh_q;
		end else if (miss) begin
			res_q.status <= is_insert ? hst_pkg::ST_FULL : hst_pkg::ST_UNKNOWN;
		end else if (ctl.data_load) begin
			res_q.address_out <= a_rd_q;
			res_q.size_out    <= s_rd_q;
		end
		if (ctl.out_load) begin
			out_q <= res_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

// File: tb/sv/tb_handle_slot_table.sv
// tb_handle_slot_table: self-checking testbench for the handle slot table.
// Depends on hst_pkg and handle_slot_table; keeps its own table predictor.
`timescale 1ns / 100ps

module tb_handle_slot_table;

	localparam int          SLOTS      = 64;
	localparam logic [1:0]  CMD_UNUSED = 2'd3;
	localparam logic [31:0] HANDLE_TOP = 32'hFFFF_FFFF;
	localparam int          MAX_CYCLES = 1_000_000;
	// covers the longest scan plus the release read and output load
	localparam int          SETTLE     = SLOTS + 16;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          req_valid = 1'b0;
	logic          req_ready;
	hst_pkg::req_t req       = '0;
	logic          rsp_valid;
	logic          rsp_ready = 1'b0;
	hst_pkg::rsp_t rsp;

	handle_slot_table #(
		.SLOTS(SLOTS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	always #4 clk = ~clk;

	// Predicted table contents. Address and size of a slot are only read
	// while its handle is nonzero, and an insert always writes them first.
	logic [31:0] slot_hnd  [SLOTS];
	logic [31:0] slot_addr [SLOTS];
	logic [31:0] slot_len  [SLOTS];
	logic [31:0] next_hnd;
	logic [31:0] last_freed;

	hst_pkg::rsp_t pending_rsp[$];   // predicted results, oldest first
	int   mismatches = 0;
	int   cycles     = 0;
	bit   quiet      = 1'b0; // no idling on either side while set
	int   stall_left = 0;

	// ------------------------------------------------------------------
	// Predictor: applies one request to the table copy and returns the
	// result the block must produce for it.
	// ------------------------------------------------------------------
	function automatic void table_clear();
		for (int i = 0; i < SLOTS; i++) begin
			slot_hnd[i] = '0;
		end
		next_hnd = 32'd1;
	endfunction

	function automatic hst_pkg::rsp_t table_outcome(hst_pkg::req_t r);
		hst_pkg::rsp_t o;
		int            slot;
		o = '0;
		slot = -1;
		case (r.cmd)
			hst_pkg::CMD_CLEAR: begin
				table_clear();
			end
			hst_pkg::CMD_INSERT: begin
				// lowest free slot wins
				for (int i = 0; i < SLOTS && slot < 0; i++) begin
					if (slot_hnd[i] == '0)
						slot = i;
				end
				if (slot < 0) begin
					o.status = hst_pkg::ST_FULL;
				end else begin
					slot_hnd[slot]  = next_hnd;
					slot_addr[slot] = r.block_address;
					slot_len[slot]  = r.block_size;
					o.handle_out    = next_hnd;
					// counter skips 0 on wrap
					next_hnd = (next_hnd == HANDLE_TOP) ? 32'd1 : next_hnd + 32'd1;
				end
			end
			hst_pkg::CMD_RELEASE: begin
				// handle 0 never matches, even though free slots hold 0
				if (r.handle_in != '0) begin
					for (int i = 0; i < SLOTS && slot < 0; i++) begin
						if (slot_hnd[i] == r.handle_in)
							slot = i;
					end
				end
				if (slot < 0) begin
					o.status = hst_pkg::ST_UNKNOWN;
				end else begin
					o.address_out  = slot_addr[slot];
					o.size_out     = slot_len[slot];
					slot_hnd[slot] = '0;
					last_freed     = r.handle_in;
				end
			end
			default: ; // unused code: state untouched, all-zero result
		endcase
		return o;
	endfunction

	// ------------------------------------------------------------------
	// Run limit
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		cycles++;
		if (cycles > MAX_CYCLES) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Result side: random back-pressure, changed at the falling edge.
	// Stalls come in short runs so they overlap every part of a scan.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			rsp_ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 99) < 1) begin
			stall_left = $urandom_range(0, 9);
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	task automatic field_check(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s mismatch: expected %h, got %h", $realtime, name, want, got);
		end
	endtask

	// Every result transfer is matched against the oldest prediction.
	always @(posedge clk) begin : rsp_check
		hst_pkg::rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result %h", $realtime, rsp);
			end else begin
				want = pending_rsp.pop_front();
				field_check("status", 32'(want.status), 32'(rsp.status));
				field_check("handle_out", want.handle_out, rsp.handle_out);
				field_check("address_out", want.address_out, rsp.address_out);
				field_check("size_out", want.size_out, rsp.size_out);
			end
		end
	end

	// ------------------------------------------------------------------
	// Request side. Each call starts and ends at a falling edge; valid is
	// dropped at the falling edge after the transfer and the call then returns
	// at a falling edge, which can come while the block is still busy with it.
	// ------------------------------------------------------------------
	task automatic send_req(logic [1:0] c, logic [31:0] a, logic [31:0] s,
			logic [31:0] h);
		hst_pkg::req_t r;
		int            gap;
		r.cmd           = c;
		r.block_address = a;
		r.block_size    = s;
		r.handle_in     = h;
		// occasional hold-off of varying length, lands anywhere in a scan
		if (!quiet && $urandom_range(0, 99) < 10) begin
			gap = $urandom_range(1, 80);
			repeat (gap) @(negedge clk);
		end
		req       <= r;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (!req_ready);
		pending_rsp.push_back(table_outcome(r));
		@(negedge clk);
		req_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Sender holds off until every predicted result has been checked.
	task automatic drain_all();
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_quiet(bit q);
		@(posedge clk);
		quiet = q;
		@(negedge clk);
	endtask

	task automatic send_insert(logic [31:0] a, logic [31:0] s);
		send_req(hst_pkg::CMD_INSERT, a, s, $urandom());
	endtask

	task automatic send_release(logic [31:0] h);
		send_req(hst_pkg::CMD_RELEASE, $urandom(), $urandom(), h);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Field extremes, each command, unknown handles, slot reuse, clear.
	// Counter wrap needs 2^32 - 1 inserts and is beyond any run length.
	task automatic test_directed();
		send_release('0);                        // handle 0 on empty table
		send_release(HANDLE_TOP);                // never issued
		send_req(CMD_UNUSED, HANDLE_TOP, HANDLE_TOP, HANDLE_TOP);
		send_req(CMD_UNUSED, '0, '0, '0);
		send_insert('0, '0);                     // handle 1, slot 0
		send_insert(HANDLE_TOP, HANDLE_TOP);     // handle 2, slot 1
		send_insert($urandom(), $urandom());     // handle 3, slot 2
		send_release(32'd2);                     // all-ones back
		send_release(32'd2);                     // already freed
		send_release('0);                        // 0 with free slots present
		send_insert(32'h5555_AAAA, 32'hAAAA_5555); // reuses slot 1, handle 4
		send_release(32'd1);                     // zeros back
		send_release(32'd4);
		send_req(hst_pkg::CMD_CLEAR, HANDLE_TOP, HANDLE_TOP, HANDLE_TOP);
		send_release(32'd3);                     // gone after clear
		send_insert($urandom(), $urandom());     // counter restarted at 1
		send_release(32'd1);
		send_req(hst_pkg::CMD_CLEAR, '0, '0, '0);
	endtask

	// Fill every slot, hit full, free one in the middle and refill it.
	task automatic test_full();
		drain_all();
		for (int i = 0; i < SLOTS; i++)
			send_insert($urandom(), $urandom());
		send_insert($urandom(), $urandom());     // full
		send_release(32'd30);                    // frees slot 29
		send_insert($urandom(), $urandom());     // lands in slot 29
		send_insert($urandom(), $urandom());     // full again
		send_release(32'(SLOTS + 1));            // handle in slot 29
		send_release(32'd1);
		send_req(hst_pkg::CMD_CLEAR, $urandom(), $urandom(), $urandom());
	endtask

	// Random episodes, each with its own insert/release balance so the
	// table spends time near empty, half full and full.
	task automatic test_random(int n_items);
		logic [31:0] live[$];
		logic [31:0] h;
		int          sent;
		int          ins_w;
		int          ep_len;
		int          pick;
		sent = 0;
		while (sent < n_items) begin
			case ($urandom_range(0, 2))
				0:       ins_w = 25;
				1:       ins_w = 50;
				default: ins_w = 80;
			endcase
			ep_len = $urandom_range(30, 150);
			for (int k = 0; k < ep_len && sent < n_items; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < ins_w) begin
					send_insert($urandom(), $urandom());
				end else if (pick < 95) begin
					live.delete();
					for (int i = 0; i < SLOTS; i++) begin
						if (slot_hnd[i] != '0)
							live.push_back(slot_hnd[i]);
					end
					if (live.size() != 0 && $urandom_range(0, 3) != 0) begin
						h = live[$urandom_range(0, live.size() - 1)];
					end else begin
						// a handle that misses, or a stale one
						case ($urandom_range(0, 3))
							0:       h = '0;
							1:       h = $urandom();
							2:       h = last_freed;
							default: h = next_hnd;
						endcase
					end
					send_release(h);
				end else if (pick < 99) begin
					send_req(CMD_UNUSED, $urandom(), $urandom(), $urandom());
				end else begin
					send_req(hst_pkg::CMD_CLEAR, $urandom(), $urandom(), $urandom());
				end
				sent++;
			end
			if ($urandom_range(0, 1)) begin
				send_req(hst_pkg::CMD_CLEAR, $urandom(), $urandom(), $urandom());
				sent++;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		table_clear();
		last_freed = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// the block's own clearing sweep follows; req_ready gates the first send

		test_directed();
		test_full();
		test_random(1000);
		drain_all();
		set_quiet(1'b1);
		test_random(870);
		set_quiet(1'b0);

		drain_all();
		repeat (SETTLE) @(negedge clk);
		if (mismatches == 0 && pending_rsp.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// File: files.f
hdl/hst_pkg.sv
hdl/hst_ctrl.sv
hdl/hst_dp.sv
hdl/handle_slot_table.sv
tb/sv/tb_handle_slot_table.sv
